FILE: src/asd_pkg.sv
`default_nettype none
package asd_pkg;

  localparam int MAX_FRAMES   = 1024;
  localparam int MAX_CHANNELS = 8;
  localparam int DEPTH        = MAX_FRAMES * MAX_CHANNELS;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int DIV_STEPS    = 26;

  localparam logic CFG_CHANNELS  = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] RPL_WRITE = 2'd0;
  localparam logic [1:0] RPL_RUN   = 2'd1;
  localparam logic [1:0] RPL_READ  = 2'd2;

  localparam logic [1:0] ASEL_IN = 2'd0;
  localparam logic [1:0] ASEL_A  = 2'd1;
  localparam logic [1:0] ASEL_B  = 2'd2;
  localparam logic [1:0] ASEL_K  = 2'd3;

  localparam logic [1:0] WSEL_IN   = 2'd0;
  localparam logic [1:0] WSEL_ZERO = 2'd1;
  localparam logic [1:0] WSEL_SCL  = 2'd2;

  typedef struct packed {
    logic [1:0] addr_sel;
    logic [1:0] wdata_sel;
    logic       mem_we;
    logic       mem_re;
    logic       run_init;
    logic       lat_a;
    logic       lat_b;
    logic       start_a;
    logic       start_b;
    logic       g_dec;
    logic       g_inc;
    logic       mul_load;
    logic       div_step;
    logic       f_inc;
    logic       ch_inc;
    logic       out_load;
    logic [1:0] out_kind;
  } cmd_t;

  typedef struct packed {
    logic run_empty;
    logic glitch;
    logic g_zero;
    logic fw_end;
    logic breaks;
    logic div_done;
    logic f_more;
    logic ch_more;
    logic out_free;
    logic dir_fwd;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/asd_dpath.sv
`default_nettype none
module asd_dpath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire asd_pkg::cmd_t      cmd_i,
  output asd_pkg::sts_t           sts_o,
  input  wire logic [9:0]         frame_index_i,
  input  wire logic [2:0]         channel_index_i,
  input  wire logic signed [15:0] sample_value_i,
  input  wire logic [10:0]        frame_count_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [1:0]              reply_kind_o,
  output logic signed [15:0]      read_value_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [15:0]        cfg_wdata_i
);

  logic signed [15:0] mem [asd_pkg::DEPTH];
  logic signed [15:0] rdata_q;

  logic [3:0]  nch_q;
  logic [15:0] thr_q;
  logic [10:0] frames_q;
  logic [2:0]  ch_q;
  logic [9:0]  f_q, g_q;
  logic signed [15:0] xa_q, xb_q;
  logic pos_q, neg_q, dir_q, sneg_q;
  logic [25:0] dvd_q;
  logic [10:0] den_q;
  logic [10:0] rem_q;
  logic [4:0]  cnt_q;
  logic        out_valid_q;
  logic [1:0]  out_kind_q;

  logic [3:0]  nch_eff;
  logic [9:0]  row;
  logic [2:0]  chan;
  logic [13:0] addr_full;
  logic [asd_pkg::ADDR_W-1:0] addr;
  logic signed [15:0] wdata, scaled;
  logic signed [16:0] diff;
  logic [16:0] dmag;
  logic [9:0]  m, num;
  logic [10:0] den;
  logic [15:0] vmag;
  logic [11:0] trial;
  logic        ge;

  assign nch_eff = (nch_q > 4'(asd_pkg::MAX_CHANNELS)) ? 4'(asd_pkg::MAX_CHANNELS) : nch_q;

  always_comb begin
    case (cmd_i.addr_sel)
      asd_pkg::ASEL_IN: begin row = frame_index_i; chan = channel_index_i; end
      asd_pkg::ASEL_A:  begin row = f_q;           chan = ch_q; end
      asd_pkg::ASEL_B:  begin row = f_q + 10'd1;   chan = ch_q; end
      default:          begin row = g_q;           chan = ch_q; end
    endcase
  end

  assign addr_full = 14'(row) * 14'(nch_eff) + 14'(chan);
  assign addr      = addr_full[asd_pkg::ADDR_W-1:0];

  assign scaled = sneg_q ? -$signed(dvd_q[15:0]) : $signed(dvd_q[15:0]);

  always_comb begin
    case (cmd_i.wdata_sel)
      asd_pkg::WSEL_IN:   wdata = sample_value_i;
      asd_pkg::WSEL_ZERO: wdata = '0;
      default:            wdata = scaled;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem[addr] <= wdata;
    if (cmd_i.mem_re) rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nch_q <= 4'd1;
      thr_q <= 16'd3000;
    end else if (cfg_we_i) begin
      if (cfg_index_i == asd_pkg::CFG_THRESHOLD) thr_q <= cfg_wdata_i;
      else                                       nch_q <= cfg_wdata_i[3:0];
    end
  end

  assign diff = 17'(xa_q) - 17'(rdata_q);
  assign dmag = diff[16] ? 17'(-diff) : 17'(diff);
  assign m    = dir_q ? (g_q - f_q) : (f_q - g_q);
  assign num  = dir_q ? (m - 10'd1) : m;
  assign den  = {1'b0, m} + (dir_q ? 11'd8 : 11'd9);
  assign vmag = rdata_q[15] ? 16'(-rdata_q) : 16'(rdata_q);
  assign trial = {rem_q, dvd_q[25]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_init) begin
      frames_q <= (frame_count_i > 11'(asd_pkg::MAX_FRAMES)) ?
                  11'(asd_pkg::MAX_FRAMES) : frame_count_i;
      ch_q <= '0;
      f_q  <= '0;
    end
    if (cmd_i.f_inc) f_q <= f_q + 10'd1;
    if (cmd_i.ch_inc) begin
      ch_q <= ch_q + 3'd1;
      f_q  <= '0;
    end
    if (cmd_i.lat_a) xa_q <= rdata_q;
    if (cmd_i.lat_b) xb_q <= rdata_q;
    if (cmd_i.start_a) begin
      g_q <= f_q; dir_q <= 1'b0;
      pos_q <= (xa_q > 0); neg_q <= (xa_q < 0);
    end
    if (cmd_i.start_b) begin
      g_q <= f_q + 10'd1; dir_q <= 1'b1;
      pos_q <= (xb_q > 0); neg_q <= (xb_q < 0);
    end
    if (cmd_i.g_dec) g_q <= g_q - 10'd1;
    if (cmd_i.g_inc) g_q <= g_q + 10'd1;
    if (cmd_i.mul_load) begin
      dvd_q  <= 26'(vmag) * 26'(num);
      den_q  <= den;
      sneg_q <= rdata_q[15];
      rem_q  <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= 11'(ge ? (trial - {1'b0, den_q}) : trial);
      dvd_q <= {dvd_q[24:0], ge};
      cnt_q <= cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_kind_q  <= asd_pkg::RPL_WRITE;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
      out_kind_q  <= cmd_i.out_kind;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reply_kind_o = out_kind_q;
  assign read_value_o = (out_kind_q == asd_pkg::RPL_READ) ? rdata_q : '0;

  assign sts_o.run_empty = (frames_q < 11'd2) || (nch_eff == 4'd0);
  assign sts_o.glitch    = dmag > {1'b0, thr_q};
  assign sts_o.g_zero    = (g_q == '0);
  assign sts_o.fw_end    = ({1'b0, g_q} + 11'd1) >= frames_q;
  assign sts_o.breaks    = (pos_q && rdata_q < 0) || (neg_q && rdata_q > 0);
  assign sts_o.div_done  = (cnt_q == 5'(asd_pkg::DIV_STEPS - 1));
  assign sts_o.f_more    = ({1'b0, f_q} + 11'd2) < frames_q;
  assign sts_o.ch_more   = ({1'b0, ch_q} + 4'd1) < nch_eff;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.dir_fwd   = dir_q;

endmodule
`default_nettype wire

FILE: src/asd_ctrl.sv
`default_nettype none
module asd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    req_type_i,
  output logic               in_ready_o,
  input  wire asd_pkg::sts_t sts_i,
  output asd_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHK     = 4'd1;
  localparam logic [3:0] S_RDA     = 4'd2;
  localparam logic [3:0] S_RDB     = 4'd3;
  localparam logic [3:0] S_CMP     = 4'd4;
  localparam logic [3:0] S_BW_NEXT = 4'd5;
  localparam logic [3:0] S_WRD     = 4'd6;
  localparam logic [3:0] S_WCHK    = 4'd7;
  localparam logic [3:0] S_DIV     = 4'd8;
  localparam logic [3:0] S_WWR     = 4'd9;
  localparam logic [3:0] S_FW_INIT = 4'd10;
  localparam logic [3:0] S_FW_NEXT = 4'd11;
  localparam logic [3:0] S_ADV     = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.addr_sel = asd_pkg::ASEL_IN;
          case (req_type_i)
            asd_pkg::REQ_WRITE: begin
              cmd_o.mem_we    = 1'b1;
              cmd_o.wdata_sel = asd_pkg::WSEL_IN;
              cmd_o.out_load  = 1'b1;
              cmd_o.out_kind  = asd_pkg::RPL_WRITE;
            end
            asd_pkg::REQ_RUN: begin
              cmd_o.run_init = 1'b1;
              state_d = S_CHK;
            end
            default: begin
              cmd_o.mem_re   = 1'b1;
              cmd_o.out_load = 1'b1;
              cmd_o.out_kind = asd_pkg::RPL_READ;
            end
          endcase
        end
      end
      S_CHK: state_d = sts_i.run_empty ? S_DONE : S_RDA;
      S_RDA: begin
        cmd_o.addr_sel = asd_pkg::ASEL_A;
        cmd_o.mem_re = 1'b1;
        state_d = S_RDB;
      end
      S_RDB: begin
        cmd_o.lat_a = 1'b1;
        cmd_o.addr_sel = asd_pkg::ASEL_B;
        cmd_o.mem_re = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.lat_b = 1'b1;
        if (sts_i.glitch) begin
          cmd_o.addr_sel  = asd_pkg::ASEL_A;
          cmd_o.wdata_sel = asd_pkg::WSEL_ZERO;
          cmd_o.mem_we    = 1'b1;
          cmd_o.start_a   = 1'b1;
          state_d = S_BW_NEXT;
        end else begin
          state_d = S_ADV;
        end
      end
      S_BW_NEXT: begin
        if (sts_i.g_zero) begin
          state_d = S_FW_INIT;
        end else begin
          cmd_o.g_dec = 1'b1;
          state_d = S_WRD;
        end
      end
      S_WRD: begin
        cmd_o.addr_sel = asd_pkg::ASEL_K;
        cmd_o.mem_re = 1'b1;
        state_d = S_WCHK;
      end
      S_WCHK: begin
        if (sts_i.breaks) begin
          state_d = sts_i.dir_fwd ? S_ADV : S_FW_INIT;
        end else begin
          cmd_o.mul_load = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_WWR;
      end
      S_WWR: begin
        cmd_o.addr_sel  = asd_pkg::ASEL_K;
        cmd_o.wdata_sel = asd_pkg::WSEL_SCL;
        cmd_o.mem_we    = 1'b1;
        state_d = sts_i.dir_fwd ? S_FW_NEXT : S_BW_NEXT;
      end
      S_FW_INIT: begin
        cmd_o.addr_sel  = asd_pkg::ASEL_B;
        cmd_o.wdata_sel = asd_pkg::WSEL_ZERO;
        cmd_o.mem_we    = 1'b1;
        cmd_o.start_b   = 1'b1;
        state_d = S_FW_NEXT;
      end
      S_FW_NEXT: begin
        if (sts_i.fw_end) begin
          state_d = S_ADV;
        end else begin
          cmd_o.g_inc = 1'b1;
          state_d = S_WRD;
        end
      end
      S_ADV: begin
        if (sts_i.f_more) begin
          cmd_o.f_inc = 1'b1;
          state_d = S_RDA;
        end else if (sts_i.ch_more) begin
          cmd_o.ch_inc = 1'b1;
          state_d = S_RDA;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = asd_pkg::RPL_RUN;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule
`default_nettype wire

FILE: src/audio_slew_deglitch.sv
`default_nettype none
// Glitch remover over a store of 8192 interleaved 16-bit samples.
// Request channel (in_valid_i/in_ready_o) carries req_type_i with its
// fields; reply channel (out_valid_o/out_ready_i) returns one item per
// request with reply_kind_o and read_value_o. Config writes (cfg_we_i,
// cfg_index_i, cfg_wdata_i) set channel count and slew threshold; issue
// them only while the block is idle.
// Write and read requests: one item per cycle while replies are taken; the
// reply appears in the cycle after acceptance, read data coming from the
// registered memory port. Run request: the single memory port and the
// shift-subtract divider set the time. A glitch between a frame pair zeroes
// the earlier sample and damps samples walking back, then zeroes the later
// one and damps walking forward, each walk ending at a sign flip or data end;
// the run reply follows the last step. No request is taken during a run.
// Reset clears control state and sets channel count 1 and threshold 3000;
// sample contents are undefined until written, and no clearing pass runs.
// When the receiver stalls, the reply holds and a new request is taken only
// in the cycle the held reply leaves.
module audio_slew_deglitch (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [9:0]         frame_index_i,
  input  wire logic [2:0]         channel_index_i,
  input  wire logic signed [15:0] sample_value_i,
  input  wire logic [10:0]        frame_count_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              reply_kind_o,
  output logic signed [15:0]      read_value_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [15:0]        cfg_wdata_i
);

  asd_pkg::cmd_t cmd;
  asd_pkg::sts_t sts;

  asd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  asd_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .frame_index_i   (frame_index_i),
    .channel_index_i (channel_index_i),
    .sample_value_i  (sample_value_i),
    .frame_count_i   (frame_count_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .reply_kind_o    (reply_kind_o),
    .read_value_o    (read_value_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.mem_we && cmd.mem_re))
    else $error("memory written and read in one cycle");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && req_type_i == asd_pkg::REQ_RUN) |=> !in_ready_o)
    else $error("request taken during a run");

  a_rw_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && req_type_i != asd_pkg::REQ_RUN) |=> out_valid_o)
    else $error("no reply after write or read");

  a_run_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && req_type_i == asd_pkg::REQ_RUN) |=> !cmd.out_load)
    else $error("run reply too early");

endmodule
`default_nettype wire

FILE: tb/asd_checker.sv
module asd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         req_type_i,
  input  logic [9:0]         frame_index_i,
  input  logic [2:0]         channel_index_i,
  input  logic signed [15:0] sample_value_i,
  input  logic [10:0]        frame_count_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         reply_kind_i,
  input  logic signed [15:0] read_value_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] value;
  } reply_t;

  logic signed [15:0] samples [asd_pkg::DEPTH];
  logic [3:0]         chan_reg;
  logic [15:0]        thresh_reg;
  reply_t             replies_due [$];

  function automatic int active_channels();
    return (chan_reg > asd_pkg::MAX_CHANNELS) ? asd_pkg::MAX_CHANNELS : int'(chan_reg);
  endfunction

  function automatic int sgn(logic signed [15:0] v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic logic signed [15:0] scaled(logic signed [15:0] v, int num, int den);
    int p;
    p = int'(v) * num;
    return 16'(p / den);
  endfunction

  function automatic bit flips(int from, logic signed [15:0] v);
    return (from > 0 && v < 0) || (from < 0 && v > 0);
  endfunction

  task automatic deglitch(int count);
    int n, frames, a, b, d, from, g, k, m;
    n = active_channels();
    frames = (count > asd_pkg::MAX_FRAMES) ? asd_pkg::MAX_FRAMES : count;
    if (frames < 2) return;
    for (int ch = 0; ch < n; ch++) begin
      for (int f = 0; f + 1 < frames; f++) begin
        a = f * n + ch;
        b = a + n;
        d = int'(samples[a]) - int'(samples[b]);
        if (d < 0) d = -d;
        if (d <= int'(thresh_reg)) continue;
        from = sgn(samples[a]);
        samples[a] = '0;
        g = f;
        while (g > 0) begin
          g--;
          k = g * n + ch;
          if (flips(from, samples[k])) break;
          m = f - g;
          samples[k] = scaled(samples[k], m, m + 9);
        end
        from = sgn(samples[b]);
        samples[b] = '0;
        g = f + 1;
        while (g + 1 < frames) begin
          g++;
          k = g * n + ch;
          if (flips(from, samples[k])) break;
          m = g - f;
          samples[k] = scaled(samples[k], m - 1, m + 8);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t exp_r;
    reply_t got;
    int     addr;
    if (!rst_ni) begin
      chan_reg   = 4'd1;
      thresh_reg = 16'd3000;
      replies_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == asd_pkg::CFG_CHANNELS) chan_reg = cfg_wdata_i[3:0];
        else if (cfg_index_i == asd_pkg::CFG_THRESHOLD) thresh_reg = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $error("unexpected reply: reply_kind %0d read_value %0d", reply_kind_i, read_value_i);
          fail_count_o++;
        end else begin
          exp_r = replies_due.pop_front();
          if (reply_kind_i !== exp_r.kind) begin
            $error("reply_kind expected %0d actual %0d", exp_r.kind, reply_kind_i);
            fail_count_o++;
          end
          if (read_value_i !== exp_r.value) begin
            $error("read_value expected %0d actual %0d", exp_r.value, read_value_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        addr = (int'(frame_index_i) * active_channels() + int'(channel_index_i)) %
               asd_pkg::DEPTH;
        got.value = '0;
        if (req_type_i == asd_pkg::REQ_WRITE) begin
          samples[addr] = sample_value_i;
          got.kind = asd_pkg::RPL_WRITE;
        end else if (req_type_i == asd_pkg::REQ_RUN) begin
          deglitch(int'(frame_count_i));
          got.kind = asd_pkg::RPL_RUN;
        end else begin
          got.kind  = asd_pkg::RPL_READ;
          got.value = samples[addr];
        end
        replies_due.push_back(got);
      end
      pending_o = replies_due.size();
    end
  end

endmodule

FILE: tb/tb.sv
module tb;

  localparam int STALL_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         req_type_i;
  logic [9:0]         frame_index_i;
  logic [2:0]         channel_index_i;
  logic signed [15:0] sample_value_i;
  logic [10:0]        frame_count_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         reply_kind_o;
  logic signed [15:0] read_value_o;
  logic               cfg_we_i;
  logic               cfg_index_i;
  logic [15:0]        cfg_wdata_i;
  int                 fail_count;
  int                 pending;

  typedef struct {
    int frame;
    int chan;
  } slot_t;

  slot_t stored_slots [$];
  int    gap_pct;
  bit    hold_req;
  int    idle_cycles;

  audio_slew_deglitch u_top (.*);

  asd_checker u_chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .req_type_i, .frame_index_i, .channel_index_i, .sample_value_i, .frame_count_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .reply_kind_i(reply_kind_o), .read_value_i(read_value_o),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= gap_pct);
      end
    end
  end

  function automatic logic signed [15:0] any_sample();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(8000) - 4000);
  endfunction

  task automatic send(logic [1:0] kind, int frame, int chan, logic signed [15:0] value,
                      int count);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    frame_index_i   <= 10'(frame);
    channel_index_i <= 3'(chan);
    sample_value_i  <= value;
    frame_count_i   <= 11'(count);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic store(int frame, int chan, logic signed [15:0] value);
    slot_t s;
    s.frame = frame;
    s.chan  = chan;
    stored_slots.push_back(s);
    send(asd_pkg::REQ_WRITE, frame, chan, value, $urandom_range(2047));
  endtask

  task automatic fetch(logic [1:0] kind);
    slot_t s;
    s = stored_slots[$urandom_range(stored_slots.size() - 1)];
    send(kind, s.frame, s.chan, any_sample(), $urandom_range(2047));
  endtask

  task automatic run(int count);
    send(asd_pkg::REQ_RUN, $urandom_range(1023), $urandom_range(7), any_sample(), count);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic setup(int chans, int thresh, int frames);
    int n;
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= asd_pkg::CFG_CHANNELS;
    cfg_wdata_i <= 16'(chans);
    @(posedge clk_i);
    cfg_index_i <= asd_pkg::CFG_THRESHOLD;
    cfg_wdata_i <= 16'(thresh);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    stored_slots.delete();
    n = (chans == 0) ? 8 : ((chans > 8) ? 8 : chans);
    for (int f = 0; f < frames; f++)
      for (int c = 0; c < n; c++) store(f, c, any_sample());
  endtask

  task automatic mix(int items, int frames);
    int r;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        store(($urandom_range(9) < 7) ? $urandom_range(frames - 1) : $urandom_range(1023),
              $urandom_range(7), any_sample());
      end else if (r < 85) begin
        fetch(($urandom_range(9) == 0) ? REQ_SPARE : asd_pkg::REQ_READ);
      end else if ($urandom_range(9) == 0) begin
        run($urandom_range(1));
      end else begin
        run($urandom_range(frames, 2));
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    req_type_i      = asd_pkg::REQ_WRITE;
    frame_index_i   = '0;
    channel_index_i = '0;
    sample_value_i  = '0;
    frame_count_i   = '0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = asd_pkg::CFG_CHANNELS;
    cfg_wdata_i     = '0;
    gap_pct         = 35;
    hold_req        = 1'b0;
    idle_cycles     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    setup(1, 3000, 24);
    store(1023, 7, 16'sh8000);
    store(0, 0, 16'sh7fff);
    store(1, 0, 16'sh0000);
    store(2, 0, -16'sd1);
    fetch(asd_pkg::REQ_READ);
    send(asd_pkg::REQ_READ, 1023, 7, '0, 0);
    send(REQ_SPARE, 0, 0, '0, 0);
    send(asd_pkg::REQ_READ, 2, 0, '0, 0);
    run(0);
    run(1);
    run(2);
    run(24);
    send(asd_pkg::REQ_READ, 0, 0, '0, 0);
    send(asd_pkg::REQ_READ, 1, 0, '0, 0);
    mix(80, 24);

    setup(8, 0, 12);
    mix(100, 12);

    setup(3, 2000, 20);
    mix(30, 20);
    hold_req = 1'b1;
    mix(100, 20);

    setup(0, 1000, 8);
    mix(60, 8);

    setup(15, 500, 10);
    mix(80, 10);

    gap_pct = 0;
    setup(2, 6000, 24);
    mix(200, 24);

    gap_pct = 35;
    setup(5, 4000, 16);
    mix(180, 16);

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/asd_pkg.sv
src/asd_dpath.sv
src/asd_ctrl.sv
src/audio_slew_deglitch.sv
tb/asd_checker.sv
tb/tb.sv
